### hw/rtl/twrtc_pkg.sv
// ============================================================================
// twrtc_pkg
// Shared types and constants for the three-wire RTC serial master.
// ============================================================================
`default_nettype none

package twrtc_pkg;

    // Number of bytes moved by a burst transaction.
    localparam int unsigned BURST_BYTES = 8;

    localparam logic [63:0] BURST_MASK = (64'd1 << (8 * BURST_BYTES)) - 64'd1;

    // Bit counts including the command byte
    localparam logic [6:0] SINGLE_TOTAL_BITS = 7'd16;
    localparam logic [6:0] BURST_TOTAL_BITS  = 7'(8 + 8 * BURST_BYTES);
    localparam logic [6:0] CMD_BYTE_BITS     = 7'd8;

    // Command byte codes
    localparam logic [7:0] CB_SINGLE_WR = 8'h80;
    localparam logic [7:0] CB_SINGLE_RD = 8'h81;
    localparam logic [7:0] CB_BURST_WR  = 8'hBE;
    localparam logic [7:0] CB_BURST_RD  = 8'hBF;

    typedef enum logic [1:0] {
        CMD_WR_SINGLE = 2'd0,
        CMD_RD_SINGLE = 2'd1,
        CMD_WR_BURST  = 2'd2,
        CMD_RD_BURST  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic        start_req;
        logic [1:0]  command;
        logic [5:0]  reg_addr;
        logic [63:0] write_data;
        logic        io_in;
    } t_in_item;

    typedef struct packed {
        logic        chip_enable;
        logic        serial_clock;
        logic        io_out;
        logic        io_drive;
        logic        busy_res;
        logic        done_res;
        logic [63:0] read_data;
    } t_out_item;

endpackage

`default_nettype wire

### hw/rtl/twrtc_seq.sv
// ============================================================================
// twrtc_seq
// Pin sequencer: transaction state and one tick of pin levels per item.
// ============================================================================
`default_nettype none

module twrtc_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire twrtc_pkg::t_in_item i_item,
    output twrtc_pkg::t_out_item     o_res
);
    import twrtc_pkg::*;

    logic        r_active,       n_active;
    t_cmd        r_op_latch,     n_op_latch;
    logic [7:0]  r_command_byte, n_command_byte;
    logic [63:0] r_out_shift,    n_out_shift;
    logic [63:0] r_in_shift,     n_in_shift;
    logic [6:0]  r_bit_count,    n_bit_count;
    logic        r_half_phase,   n_half_phase;

    logic        starting;
    logic [6:0]  total_bits;
    logic [6:0]  bit_off;
    logic [5:0]  pos;
    logic        reading;
    logic [7:0]  start_cbyte;
    logic [63:0] start_oshift;

    always_comb begin
        // command byte and write data taken at a start
        unique case (t_cmd'(i_item.command))
            CMD_WR_SINGLE: start_cbyte = {1'b0, i_item.reg_addr, 1'b0} | CB_SINGLE_WR;
            CMD_RD_SINGLE: start_cbyte = {1'b0, i_item.reg_addr, 1'b0} | CB_SINGLE_RD;
            CMD_WR_BURST:  start_cbyte = CB_BURST_WR;
            CMD_RD_BURST:  start_cbyte = CB_BURST_RD;
            default:       start_cbyte = CB_BURST_RD;
        endcase
        unique case (t_cmd'(i_item.command))
            CMD_WR_SINGLE: start_oshift = {56'd0, i_item.write_data[7:0]};
            CMD_WR_BURST:  start_oshift = i_item.write_data & BURST_MASK;
            default:       start_oshift = 64'd0;
        endcase
    end

    always_comb begin
        starting = !r_active && i_item.start_req;

        // effective state after a possible start
        n_active       = r_active || starting;
        n_op_latch     = starting ? t_cmd'(i_item.command) : r_op_latch;
        n_command_byte = starting ? start_cbyte  : r_command_byte;
        n_out_shift    = starting ? start_oshift : r_out_shift;
        n_in_shift     = starting ? 64'd0        : r_in_shift;
        n_bit_count    = starting ? 7'd0         : r_bit_count;
        n_half_phase   = starting ? 1'b0         : r_half_phase;

        total_bits = (n_op_latch == CMD_WR_BURST || n_op_latch == CMD_RD_BURST)
                     ? BURST_TOTAL_BITS : SINGLE_TOTAL_BITS;
        reading    = (n_op_latch == CMD_RD_SINGLE || n_op_latch == CMD_RD_BURST);
        bit_off    = n_bit_count - CMD_BYTE_BITS;
        pos        = bit_off[5:0];

        o_res = '0;

        if (n_active) begin
            if (n_bit_count >= total_bits) begin
                // end of transaction: CE low, done pulse, read bytes out
                o_res.done_res  = 1'b1;
                o_res.read_data = n_in_shift;
                n_active        = 1'b0;
                n_bit_count     = 7'd0;
                n_half_phase    = 1'b0;
            end else begin
                o_res.chip_enable  = 1'b1;
                o_res.busy_res     = 1'b1;
                o_res.serial_clock = n_half_phase;
                if (n_bit_count < CMD_BYTE_BITS) begin
                    o_res.io_drive = 1'b1;
                    o_res.io_out   = n_command_byte[n_bit_count[2:0]];
                end else if (reading) begin
                    // sample with the clock still low
                    if (!n_half_phase) begin
                        n_in_shift[pos] = n_in_shift[pos] | i_item.io_in;
                    end
                end else begin
                    o_res.io_drive = 1'b1;
                    o_res.io_out   = n_out_shift[pos];
                end
                if (n_half_phase) begin
                    n_half_phase = 1'b0;
                    n_bit_count  = n_bit_count + 7'd1;
                end else begin
                    n_half_phase = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_op_latch     <= CMD_WR_SINGLE;
            r_command_byte <= 8'd0;
            r_out_shift    <= 64'd0;
            r_in_shift     <= 64'd0;
            r_bit_count    <= 7'd0;
            r_half_phase   <= 1'b0;
        end else if (i_en) begin
            r_active       <= n_active;
            r_op_latch     <= n_op_latch;
            r_command_byte <= n_command_byte;
            r_out_shift    <= n_out_shift;
            r_in_shift     <= n_in_shift;
            r_bit_count    <= n_bit_count;
            r_half_phase   <= n_half_phase;
        end
    end

    // clock-high phase only exists inside a transaction
    a_half_in_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half_phase |-> r_active)
        else $error("half phase set while idle");

    // idle sequencer always rests at bit zero, clock low
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_bit_count == 7'd0 && !r_half_phase))
        else $error("idle with stale bit counter");

    // bit counter never runs past the end of the transaction
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_bit_count <= ((r_op_latch == CMD_WR_BURST ||
                                       r_op_latch == CMD_RD_BURST)
                                      ? BURST_TOTAL_BITS : SINGLE_TOTAL_BITS)))
        else $error("bit counter overran transaction");

endmodule

`default_nettype wire

### hw/rtl/three_wire_rtc_serial_master.sv
// ============================================================================
// three_wire_rtc_serial_master
// Tick-level master for a three-wire RTC serial link (CE, SCLK, IO).
// ============================================================================
// Path: an accepted tick goes through the input register, then the result
//   register, before it reaches the output port.
// Throughput: one tick per cycle while the result slot is free or draining;
//   the sequencer step is a single pass of logic between those two registers.
// Reset: i_rst_n synchronous, active low; pipeline empty, sequencer idle
//   (CE low, clock low, data pin released).
// ============================================================================
`default_nettype none

module three_wire_rtc_serial_master (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // tick input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire twrtc_pkg::t_in_item  i_in_item,
    // pin-level result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output twrtc_pkg::t_out_item      o_out_item
);
    import twrtc_pkg::*;

    // Input register: holds one accepted tick until the sequencer steps.
    logic      r_in_valid;
    t_in_item  r_in_item;

    // Result register: one tick of pin levels waiting for the consumer.
    logic      r_out_valid;
    t_out_item r_out_item;

    // Sequencer steps when a tick is held and the result slot is free or
    // draining this cycle. Sequencer state moves only on a step, so stalls
    // on either side never skip or repeat a tick.
    logic      advance;
    t_out_item seq_res;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    twrtc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in_item),
        .o_res   (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= seq_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### test/twrtc_tb_pkg.sv
// ============================================================================
// twrtc_tb_pkg
// Pin-level scoreboard for the three-wire RTC serial master: predicts the
// expected pin levels for every accepted tick and checks results in order.
// ============================================================================
`default_nettype none

package twrtc_tb_pkg;

    import twrtc_pkg::*;

    class pin_scoreboard;

        t_out_item   expected_pins[$];
        int unsigned fails;
        int unsigned results_seen;
        int unsigned done_seen;

        // sequencer state
        logic        active;
        t_cmd        op;
        logic [7:0]  cmd_byte;
        logic [63:0] out_bits;
        logic [63:0] in_bits;
        logic [6:0]  bit_idx;
        logic        clk_high;

        function new();
            fails        = 0;
            results_seen = 0;
            done_seen    = 0;
            active       = 1'b0;
            op           = CMD_WR_SINGLE;
            cmd_byte     = '0;
            out_bits     = '0;
            in_bits      = '0;
            bit_idx      = '0;
            clk_high     = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_pins.size();
        endfunction

        // One sequencer tick: pin levels for this tick, state advanced.
        function t_out_item predict_pins(t_in_item it);
            t_out_item  pins;
            logic [6:0] last_bit;
            logic [5:0] pos;
            pins = '0;
            if (!active && it.start_req) begin
                active = 1'b1;
                op     = t_cmd'(it.command);
                case (op)
                    CMD_WR_SINGLE: cmd_byte = CB_SINGLE_WR | {1'b0, it.reg_addr, 1'b0};
                    CMD_RD_SINGLE: cmd_byte = CB_SINGLE_RD | {1'b0, it.reg_addr, 1'b0};
                    CMD_WR_BURST:  cmd_byte = CB_BURST_WR;
                    default:       cmd_byte = CB_BURST_RD;
                endcase
                if (op == CMD_WR_SINGLE)
                    out_bits = {56'd0, it.write_data[7:0]};
                else if (op == CMD_WR_BURST)
                    out_bits = it.write_data & BURST_MASK;
                else
                    out_bits = '0;
                in_bits  = '0;
                bit_idx  = '0;
                clk_high = 1'b0;
            end
            if (active) begin
                last_bit = op[1] ? BURST_TOTAL_BITS : SINGLE_TOTAL_BITS;
                if (bit_idx >= last_bit) begin
                    pins.done_res  = 1'b1;
                    pins.read_data = in_bits;
                    active   = 1'b0;
                    bit_idx  = '0;
                    clk_high = 1'b0;
                end else begin
                    pins.chip_enable  = 1'b1;
                    pins.busy_res     = 1'b1;
                    pins.serial_clock = clk_high;
                    if (bit_idx < CMD_BYTE_BITS) begin
                        pins.io_drive = 1'b1;
                        pins.io_out   = cmd_byte[bit_idx[2:0]];
                    end else begin
                        pos = 6'(bit_idx - CMD_BYTE_BITS);
                        if (op[0]) begin
                            // read bits are sampled in the clock-low half only
                            if (!clk_high)
                                in_bits[pos] = in_bits[pos] | it.io_in;
                        end else begin
                            pins.io_drive = 1'b1;
                            pins.io_out   = out_bits[pos];
                        end
                    end
                    if (clk_high) begin
                        clk_high = 1'b0;
                        bit_idx  = bit_idx + 7'd1;
                    end else begin
                        clk_high = 1'b1;
                    end
                end
            end
            return pins;
        endfunction

        function void note_tick(t_in_item it);
            expected_pins.push_back(predict_pins(it));
        endfunction

        task report(string msg);
            fails++;
            // keep the log readable when the block is badly off
            if (fails <= 60)
                $display("ERROR: %s", msg);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("result %0d field %s: got %h, want %h",
                                 results_seen, name, got, want));
        endtask

        task check_pins(t_out_item got);
            t_out_item want;
            results_seen++;
            if (expected_pins.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            want = expected_pins.pop_front();
            if (want.done_res)
                done_seen++;
            compare_field("chip_enable",  64'(got.chip_enable),  64'(want.chip_enable));
            compare_field("serial_clock", 64'(got.serial_clock), 64'(want.serial_clock));
            compare_field("io_out",       64'(got.io_out),       64'(want.io_out));
            compare_field("io_drive",     64'(got.io_drive),     64'(want.io_drive));
            compare_field("busy_res",     64'(got.busy_res),     64'(want.busy_res));
            compare_field("done_res",     64'(got.done_res),     64'(want.done_res));
            compare_field("read_data",    got.read_data,         want.read_data);
        endtask

    endclass

endpackage

`default_nettype wire

### test/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the three-wire RTC serial master: directed and
// random transactions, tick by tick, under varying sender and sink pressure.
// ============================================================================
`default_nettype none

module testbench;

    import twrtc_pkg::*;
    import twrtc_tb_pkg::*;

    // data pin behavior during a transaction
    typedef enum int {IO_LOW, IO_HIGH, IO_RANDOM} t_io_pattern;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_TICKS  = 230;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          NUM_PHASES   = 4;

    // idle / stall percentages per random phase
    int phase_idle[NUM_PHASES]  = '{0, 68, 0, 22};
    int phase_stall[NUM_PHASES] = '{0, 0, 68, 22};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    pin_scoreboard sb;

    int          idle_pct       = 0;
    int          stall_pct      = 0;
    int unsigned tick_count     = 0;
    int unsigned single_started = 0;
    int unsigned burst_started  = 0;
    int unsigned cycle_count    = 0;

    three_wire_rtc_serial_master i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stalls per the current phase, and every accepted
    // result goes to the scoreboard. Sampling at the edge sees pre-edge values.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_pins(o_out_item);
    end

    function automatic t_in_item random_tick();
        t_in_item it;
        it.start_req  = 1'($urandom_range(1));
        it.command    = 2'($urandom_range(3));
        it.reg_addr   = 6'($urandom_range(63));
        it.write_data = {$urandom, $urandom};
        it.io_in      = 1'($urandom_range(1));
        return it;
    endfunction

    // Offer one tick, with random sender gaps ahead of it; returns at the
    // edge where it was taken, so the next call keeps valid high seamlessly.
    task automatic send_tick(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_tick(it);
        tick_count++;
    endtask

    // Sender pause: nothing offered until every expected result is back.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // A full transaction: start tick, the bit ticks, the done tick, then a
    // gap of idle ticks. Fields after the start tick are junk the block must
    // ignore; hold_start keeps start high through busy and done ticks.
    task automatic run_transaction(input t_cmd cmd, input logic [5:0] addr,
                                   input logic [63:0] wdata, input t_io_pattern io_mode,
                                   input bit hold_start, input int gap);
        t_in_item it;
        int       n_ticks;
        n_ticks = cmd[1] ? 2 * BURST_TOTAL_BITS + 1 : 2 * SINGLE_TOTAL_BITS + 1;
        if (cmd[1])
            burst_started++;
        else
            single_started++;
        for (int k = 0; k < n_ticks + gap; k++) begin
            it = random_tick();
            if (k == 0) begin
                it.start_req  = 1'b1;
                it.command    = cmd;
                it.reg_addr   = addr;
                it.write_data = wdata;
            end else if (k < n_ticks) begin
                if (hold_start)
                    it.start_req = 1'b1;
            end else begin
                it.start_req = 1'b0;
            end
            case (io_mode)
                IO_LOW:  it.io_in = 1'b0;
                IO_HIGH: it.io_in = 1'b1;
                default: ;
            endcase
            send_tick(it);
        end
    endtask

    // Mostly singles (short), some bursts; data and pin levels random.
    task automatic random_transaction();
        t_cmd        cmd;
        t_io_pattern pattern;
        int unsigned r;
        r = $urandom_range(9);
        if (r < 7)
            cmd = r[0] ? CMD_RD_SINGLE : CMD_WR_SINGLE;
        else
            cmd = r[0] ? CMD_RD_BURST : CMD_WR_BURST;
        r = $urandom_range(9);
        pattern = (r == 0) ? IO_LOW : (r == 1) ? IO_HIGH : IO_RANDOM;
        run_transaction(cmd, 6'($urandom_range(63)), {$urandom, $urandom}, pattern,
                        $urandom_range(7) == 0, $urandom_range(3));
    endtask

    initial begin
        t_in_item    quiet;
        int unsigned phase_end;
        int unsigned n_noise;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part, no gaps or stalls ---
        // idle ticks: every pin low, line released
        for (int k = 0; k < 3; k++) begin
            quiet = random_tick();
            quiet.start_req = 1'b0;
            send_tick(quiet);
        end
        // address extremes, write data all ones / all zeros, back-to-back start
        run_transaction(CMD_WR_SINGLE, 6'd0,  '1, IO_LOW,  1'b0, 0);
        run_transaction(CMD_WR_SINGLE, 6'd63, '0, IO_HIGH, 1'b0, 1);
        // start held high through busy and done ticks must be ignored
        run_transaction(CMD_RD_SINGLE, 6'd0,  '1, IO_HIGH, 1'b1, 0);
        run_transaction(CMD_RD_SINGLE, 6'd63, '0, IO_LOW,  1'b0, 2);
        run_transaction(CMD_RD_SINGLE, 6'h2A, 64'h0123_4567_89AB_CDEF, IO_RANDOM, 1'b0, 0);
        run_transaction(CMD_WR_BURST,  6'd0,  '1, IO_RANDOM, 1'b1, 0);
        run_transaction(CMD_WR_BURST,  6'd63, 64'hA5A5_5A5A_0FF0_F00F, IO_RANDOM, 1'b0, 1);
        // burst reads with the pin stuck high, then stuck low
        run_transaction(CMD_RD_BURST,  6'd0,  '0, IO_HIGH, 1'b0, 0);
        run_transaction(CMD_RD_BURST,  6'd63, '1, IO_LOW,  1'b1, 3);

        // --- random part, one pressure setting per phase ---
        for (int p = 0; p < NUM_PHASES; p++) begin
            hold_until_drained();
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            phase_end = tick_count + PHASE_TICKS;
            while (tick_count < phase_end) begin
                if ($urandom_range(99) < 85) begin
                    random_transaction();
                end else begin
                    // noise: fully random ticks, may start or break sequences
                    n_noise = $urandom_range(12, 1);
                    repeat (n_noise) send_tick(random_tick());
                end
            end
        end

        // drain, then keep clocking to catch stray results
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Drove %0d ticks: %0d single and %0d burst transactions requested, %0d done pulses checked,",
                 tick_count, single_started, burst_started, sb.done_seen);
        $display("across free-flowing, sender-gapped, sink-stalled and mixed pressure phases.");
        if (sb.fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### three_wire_rtc_serial_master.f
hw/rtl/twrtc_pkg.sv
hw/rtl/twrtc_seq.sv
hw/rtl/three_wire_rtc_serial_master.sv
test/twrtc_tb_pkg.sv
test/testbench.sv
